@@ rtl/core/i2cm_pkg.sv @@
package i2cm_pkg;

	// Request codes on the input channel
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	// Command queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int QPTR_W  = $clog2(Q_DEPTH);
	localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

	// Register indexes
	localparam logic REG_DEVICE_ADDRESS = 1'b0;
	localparam logic REG_ACK_WAIT_LIMIT = 1'b1;

	// Reset values of the registers
	localparam logic [6:0] DEVICE_ADDRESS_RST = 7'd80;
	localparam logic [7:0] ACK_WAIT_LIMIT_RST = 8'd250;

	// Item class decided by the front end
	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_READ  = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	// Bus sequencer phases
	typedef enum logic [9:0] {
		PH_IDLE     = 10'b0000000001,
		PH_START    = 10'b0000000010,
		PH_WBIT     = 10'b0000000100,
		PH_ACKLOW   = 10'b0000001000,
		PH_ACKWAIT  = 10'b0000010000,
		PH_RESTART  = 10'b0000100000,
		PH_RBIT     = 10'b0001000000,
		PH_MNACK    = 10'b0010000000,
		PH_STOP     = 10'b0100000000,
		PH_STOPEND  = 10'b1000000000
	} phase_t;

	// Classified item as it sits in the queue
	typedef struct packed {
		kind_t      kind;
		logic [7:0] word_address;
		logic [7:0] write_data;
		logic       sda_in;
	} item_t;

	// Queue status seen by the front end and back end
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// Configuration registers handed to the sequencer
	typedef struct packed {
		logic [6:0] device_address;
		logic [7:0] ack_wait_limit;
	} cfg_t;

	// One result item
	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       ack_missing;
		logic       rejected;
	} result_t;

endpackage

@@ rtl/core/i2cm_front.sv @@
module i2cm_front
	import i2cm_pkg::*;
(
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] req_type,
	input  logic [7:0] word_address,
	input  logic [7:0] write_data,
	input  logic       sda_in,
	input  q_stat_t    q_stat,
	output logic       push,
	output item_t      push_item
);

	// Take a transaction whenever the queue has room
	assign in_ready = !q_stat.full;
	assign push     = in_valid && !q_stat.full;

	// Classify the request code
	always_comb begin
		case (req_type)
			REQ_TICK:  push_item.kind = KIND_TICK;
			REQ_WRITE: push_item.kind = KIND_WRITE;
			REQ_READ:  push_item.kind = KIND_READ;
			default:   push_item.kind = KIND_NONE;
		endcase
		push_item.word_address = word_address;
		push_item.write_data   = write_data;
		push_item.sda_in       = sda_in;
	end

endmodule

@@ rtl/core/i2cm_queue.sv @@
module i2cm_queue
	import i2cm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  item_t   push_item,
	input  logic    pop,
	output item_t   head_item,
	output q_stat_t q_stat
);

	item_t              mem_q [Q_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign q_stat.empty = (count_q == '0);
	assign q_stat.full  = (count_q == QCNT_W'(Q_DEPTH));
	assign head_item    = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/i2cm_back.sv @@
module i2cm_back
	import i2cm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  q_stat_t q_stat,
	input  item_t   head_item,
	output logic    pop,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t res
);

	// Sequencer state
	phase_t      phase_q;
	logic        half_q;
	logic [3:0]  bcnt_q;
	logic [7:0]  shift_q;
	logic [1:0]  bidx_q;
	logic [7:0]  ackc_q;
	logic        is_read_q;
	logic [7:0]  haddr_q;
	logic [7:0]  hdata_q;
	logic        nack_q;
	logic        scl_q;
	logic        sda_q;

	// Next values
	phase_t      phase_n;
	logic        half_n;
	logic [3:0]  bcnt_n;
	logic [7:0]  shift_n;
	logic [1:0]  bidx_n;
	logic [7:0]  ackc_n;
	logic        is_read_n;
	logic [7:0]  haddr_n;
	logic [7:0]  hdata_n;
	logic        nack_n;
	logic        scl_n;
	logic        sda_n;
	logic        done_n;
	logic        rej_n;
	logic [7:0]  rdata_n;
	logic [3:0]  bcnt_inc;
	logic [7:0]  ackc_inc;

	// Output register
	logic        out_valid_q;
	result_t     res_q;

	assign pop       = !q_stat.empty && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign res       = res_q;
	assign bcnt_inc  = bcnt_q + 4'd1;
	assign ackc_inc  = ackc_q + 8'd1;

	// One bus step per transaction
	always_comb begin
		phase_n   = phase_q;
		half_n    = half_q;
		bcnt_n    = bcnt_q;
		shift_n   = shift_q;
		bidx_n    = bidx_q;
		ackc_n    = ackc_q;
		is_read_n = is_read_q;
		haddr_n   = haddr_q;
		hdata_n   = hdata_q;
		nack_n    = nack_q;
		scl_n     = scl_q;
		sda_n     = sda_q;
		done_n    = 1'b0;
		rej_n     = 1'b0;
		rdata_n   = 8'd0;
		case (head_item.kind)
			KIND_WRITE, KIND_READ: begin
				if (phase_q != PH_IDLE) begin
					rej_n = 1'b1;
				end else begin
					is_read_n = (head_item.kind == KIND_READ);
					haddr_n   = head_item.word_address;
					hdata_n   = head_item.write_data;
					nack_n    = 1'b0;
					bidx_n    = 2'd0;
					bcnt_n    = 4'd0;
					half_n    = 1'b0;
					ackc_n    = 8'd0;
					shift_n   = 8'd0;
					phase_n   = PH_START;
				end
			end
			KIND_TICK: begin
				case (phase_q)
					PH_IDLE: begin
						scl_n = 1'b1;
						sda_n = 1'b1;
					end
					PH_START: begin
						if (!half_q) begin
							scl_n  = 1'b1;
							sda_n  = 1'b1;
							half_n = 1'b1;
						end else begin
							scl_n   = 1'b1;
							sda_n   = 1'b0;
							// R/W bit is set on the repeated start
							shift_n = {cfg.device_address, (bidx_q != 2'd0)};
							bcnt_n  = 4'd0;
							half_n  = 1'b0;
							phase_n = PH_WBIT;
						end
					end
					PH_WBIT: begin
						sda_n = shift_q[7];
						if (!half_q) begin
							scl_n  = 1'b0;
							half_n = 1'b1;
						end else begin
							scl_n   = 1'b1;
							shift_n = {shift_q[6:0], 1'b0};
							bcnt_n  = bcnt_inc;
							half_n  = 1'b0;
							if (bcnt_inc[3]) begin
								phase_n = PH_ACKLOW;
							end
						end
					end
					PH_ACKLOW: begin
						scl_n   = 1'b0;
						sda_n   = 1'b1;
						ackc_n  = 8'd0;
						half_n  = 1'b0;
						phase_n = PH_ACKWAIT;
					end
					PH_ACKWAIT: begin
						sda_n = 1'b1;
						if (!half_q) begin
							scl_n  = 1'b1;
							half_n = 1'b1;
						end else if (!head_item.sda_in) begin
							// ACK seen: pick the next step
							scl_n  = 1'b0;
							half_n = 1'b0;
							bcnt_n = 4'd0;
							case (bidx_q)
								2'd0: begin
									bidx_n  = 2'd1;
									shift_n = haddr_q;
									phase_n = PH_WBIT;
								end
								2'd1: begin
									bidx_n = 2'd2;
									if (is_read_q) begin
										phase_n = PH_RESTART;
									end else begin
										shift_n = hdata_q;
										phase_n = PH_WBIT;
									end
								end
								default: begin
									if (is_read_q) begin
										shift_n = 8'd0;
										phase_n = PH_RBIT;
									end else begin
										phase_n = PH_STOP;
									end
								end
							endcase
						end else begin
							ackc_n = ackc_inc;
							if (ackc_inc >= cfg.ack_wait_limit) begin
								// timeout: abandon with a stop
								nack_n  = 1'b1;
								scl_n   = 1'b0;
								half_n  = 1'b0;
								phase_n = PH_STOP;
							end else begin
								scl_n = 1'b1;
							end
						end
					end
					PH_RESTART: begin
						scl_n   = 1'b0;
						sda_n   = 1'b1;
						half_n  = 1'b0;
						phase_n = PH_START;
					end
					PH_RBIT: begin
						sda_n = 1'b1;
						if (!half_q) begin
							if (bcnt_q != 4'd0) begin
								shift_n = {shift_q[6:0], head_item.sda_in};
							end
							scl_n = 1'b0;
							if (bcnt_q[3]) begin
								phase_n = PH_MNACK;
							end else begin
								half_n = 1'b1;
							end
						end else begin
							scl_n  = 1'b1;
							bcnt_n = bcnt_inc;
							half_n = 1'b0;
						end
					end
					PH_MNACK: begin
						scl_n   = 1'b1;
						sda_n   = 1'b1;
						half_n  = 1'b0;
						phase_n = PH_STOP;
					end
					PH_STOP: begin
						sda_n = 1'b0;
						if (!half_q) begin
							scl_n  = 1'b0;
							half_n = 1'b1;
						end else begin
							scl_n   = 1'b1;
							half_n  = 1'b0;
							phase_n = PH_STOPEND;
						end
					end
					PH_STOPEND: begin
						scl_n   = 1'b1;
						sda_n   = 1'b1;
						done_n  = 1'b1;
						if (is_read_q && !nack_q) begin
							rdata_n = shift_q;
						end
						phase_n = PH_IDLE;
					end
					default: begin
						scl_n   = 1'b1;
						sda_n   = 1'b1;
						phase_n = PH_IDLE;
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	// State and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			half_q      <= 1'b0;
			bcnt_q      <= 4'd0;
			shift_q     <= 8'd0;
			bidx_q      <= 2'd0;
			ackc_q      <= 8'd0;
			is_read_q   <= 1'b0;
			haddr_q     <= 8'd0;
			hdata_q     <= 8'd0;
			nack_q      <= 1'b0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q   <= phase_n;
				half_q    <= half_n;
				bcnt_q    <= bcnt_n;
				shift_q   <= shift_n;
				bidx_q    <= bidx_n;
				ackc_q    <= ackc_n;
				is_read_q <= is_read_n;
				haddr_q   <= haddr_n;
				hdata_q   <= hdata_n;
				nack_q    <= nack_n;
				scl_q     <= scl_n;
				sda_q     <= sda_n;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			res_q.scl_level   <= scl_n;
			res_q.sda_level   <= sda_n;
			res_q.busy_res    <= (phase_n != PH_IDLE);
			res_q.done_res    <= done_n;
			res_q.read_data   <= rdata_n;
			res_q.ack_missing <= nack_n;
			res_q.rejected    <= rej_n;
		end
	end

endmodule

@@ rtl/core/i2c_eeprom_byte_access_master.sv @@
// Channel  Handshake             Payload
// in       in_valid / in_ready   req_type, word_address, write_data, sda_in
// out      out_valid / out_ready scl_level, sda_level, busy_res, done_res,
//                                read_data, ack_missing, rejected
// cfg      APB write, pready=1   device_address @0x0, ack_wait_limit @0x4
//
// One transaction per clock sustained while the output is not stalled; each
// input is registered in the two-entry command queue, then in the output
// register by the bus sequencer step. Async reset clears the queue and the
// sequencer (idle, lines released), loads cfg defaults, drops out_valid.
// A stalled output holds the sequencer; the queue takes inputs until full.
module i2c_eeprom_byte_access_master
	import i2cm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [7:0]  word_address,
	input  logic [7:0]  write_data,
	input  logic        sda_in,
	// output channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        scl_level,
	output logic        sda_level,
	output logic        busy_res,
	output logic        done_res,
	output logic [7:0]  read_data,
	output logic        ack_missing,
	output logic        rejected
);

	cfg_t    cfg_q;
	q_stat_t q_stat;
	item_t   push_item;
	item_t   head_item;
	logic    push;
	logic    pop;
	result_t res;
	logic    cfg_wr;

	// Register file
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_address <= DEVICE_ADDRESS_RST;
			cfg_q.ack_wait_limit <= ACK_WAIT_LIMIT_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_DEVICE_ADDRESS: cfg_q.device_address <= pwdata[6:0];
				REG_ACK_WAIT_LIMIT: cfg_q.ack_wait_limit <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_DEVICE_ADDRESS: prdata = {25'd0, cfg_q.device_address};
			REG_ACK_WAIT_LIMIT: prdata = {24'd0, cfg_q.ack_wait_limit};
			default:            prdata = 32'd0;
		endcase
	end

	i2cm_front u_front (
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.word_address (word_address),
		.write_data   (write_data),
		.sda_in       (sda_in),
		.q_stat       (q_stat),
		.push         (push),
		.push_item    (push_item)
	);

	i2cm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.q_stat    (q_stat)
	);

	i2cm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_stat    (q_stat),
		.head_item (head_item),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	assign scl_level   = res.scl_level;
	assign sda_level   = res.sda_level;
	assign busy_res    = res.busy_res;
	assign done_res    = res.done_res;
	assign read_data   = res.read_data;
	assign ack_missing = res.ack_missing;
	assign rejected    = res.rejected;

`ifndef ASSERT_OFF
	// end of stop leaves the sequencer idle
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res)
		else $error("done with busy still set");

	// a received byte only shows up with done
	a_rdata_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (read_data != 8'd0) |-> done_res)
		else $error("read data outside done");

	// a rejected command leaves the running transaction busy
	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rejected |-> busy_res && !done_res)
		else $error("reject while idle");
`endif

endmodule

@@ tb/tb_i2c_eeprom_byte_access_master.sv @@
`default_nettype none

module tb_i2c_eeprom_byte_access_master;
	timeunit 1ns;
	timeprecision 1ps;

	import i2cm_pkg::*;

	localparam logic [1:0] REQ_IGNORED = 2'd3;
	localparam int unsigned WATCHDOG_LIMIT = 3000;
	localparam int unsigned LONG_HOLD_AT = 150;
	localparam int unsigned LONG_HOLD_CYCLES = 60;
	localparam int unsigned SETTLE_CYCLES = 16;

	// One request on the input channel
	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] word_address;
		logic [7:0] write_data;
		logic       sda_in;
	} bus_req_t;

	// Sequencer state as the predictor tracks it
	typedef struct packed {
		phase_t     phase;
		logic       half_bit;
		logic [3:0] bit_count;
		logic [7:0] shift_byte;
		logic [1:0] byte_index;
		logic [7:0] ack_counter;
		logic       is_read;
		logic [7:0] held_address;
		logic [7:0] held_data;
		logic       nack_seen;
		logic       scl_drv;
		logic       sda_drv;
	} bus_state_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  req_type = REQ_TICK;
	logic [7:0]  word_address = '0;
	logic [7:0]  write_data = '0;
	logic        sda_in = 1'b1;
	logic        out_valid;
	logic        out_ready = 1'b1;
	logic        scl_level;
	logic        sda_level;
	logic        busy_res;
	logic        done_res;
	logic [7:0]  read_data;
	logic        ack_missing;
	logic        rejected;

	i2c_eeprom_byte_access_master u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.word_address (word_address),
		.write_data   (write_data),
		.sda_in       (sda_in),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.scl_level    (scl_level),
		.sda_level    (sda_level),
		.busy_res     (busy_res),
		.done_res     (done_res),
		.read_data    (read_data),
		.ack_missing  (ack_missing),
		.rejected     (rejected)
	);

	always #4 clk = ~clk;

	// Shared between stimulus, driver and monitor
	bus_req_t    tx_pending[$];
	result_t     expected_bus_results[$];
	bus_state_t  line_model;
	bus_state_t  plan_model;
	cfg_t        cfg_now;
	cfg_t        plan_cfg;
	bus_req_t    on_wire;
	bit          steady_tail = 1'b0;
	int unsigned items_planned = 0;
	int unsigned mismatches = 0;
	int unsigned results_seen = 0;
	int unsigned quiet_cycles = 0;

	function automatic bus_state_t released_bus();
		bus_state_t s;
		s = '0;
		s.phase = PH_IDLE;
		s.scl_drv = 1'b1;
		s.sda_drv = 1'b1;
		return s;
	endfunction

	// Advance the bus sequencer by one request and return the result it shows
	function automatic result_t i2c_bus_step(inout bus_state_t s, input cfg_t c,
			input bus_req_t r);
		result_t res;
		logic    done;
		logic    rej;
		logic [7:0] rdata;
		logic    bit_out;
		done = 1'b0;
		rej = 1'b0;
		rdata = '0;
		if (r.req_type == REQ_WRITE || r.req_type == REQ_READ) begin
			if (s.phase != PH_IDLE) begin
				rej = 1'b1;
			end else begin
				s.is_read = (r.req_type == REQ_READ);
				s.held_address = r.word_address;
				s.held_data = r.write_data;
				s.nack_seen = 1'b0;
				s.byte_index = '0;
				s.bit_count = '0;
				s.half_bit = 1'b0;
				s.ack_counter = '0;
				s.shift_byte = '0;
				s.phase = PH_START;
			end
		end else if (r.req_type == REQ_TICK) begin
			case (s.phase)
				PH_IDLE: begin
					s.scl_drv = 1'b1;
					s.sda_drv = 1'b1;
				end
				PH_START: begin
					if (!s.half_bit) begin
						s.scl_drv = 1'b1;
						s.sda_drv = 1'b1;
						s.half_bit = 1'b1;
					end else begin
						// start condition: SDA falls while SCL high
						s.scl_drv = 1'b1;
						s.sda_drv = 1'b0;
						s.shift_byte = {c.device_address, s.byte_index != 2'd0};
						s.bit_count = '0;
						s.half_bit = 1'b0;
						s.phase = PH_WBIT;
					end
				end
				PH_WBIT: begin
					bit_out = s.shift_byte[7];
					s.sda_drv = bit_out;
					if (!s.half_bit) begin
						s.scl_drv = 1'b0;
						s.half_bit = 1'b1;
					end else begin
						s.scl_drv = 1'b1;
						s.shift_byte = {s.shift_byte[6:0], 1'b0};
						s.bit_count = s.bit_count + 4'd1;
						s.half_bit = 1'b0;
						if (s.bit_count >= 4'd8)
							s.phase = PH_ACKLOW;
					end
				end
				PH_ACKLOW: begin
					s.scl_drv = 1'b0;
					s.sda_drv = 1'b1;
					s.ack_counter = '0;
					s.half_bit = 1'b0;
					s.phase = PH_ACKWAIT;
				end
				PH_ACKWAIT: begin
					if (!s.half_bit) begin
						s.scl_drv = 1'b1;
						s.sda_drv = 1'b1;
						s.half_bit = 1'b1;
					end else if (!r.sda_in) begin
						// slave acknowledged: pick the next step
						s.scl_drv = 1'b0;
						s.sda_drv = 1'b1;
						s.half_bit = 1'b0;
						s.bit_count = '0;
						case (s.byte_index)
							2'd0: begin
								s.byte_index = 2'd1;
								s.shift_byte = s.held_address;
								s.phase = PH_WBIT;
							end
							2'd1: begin
								s.byte_index = 2'd2;
								if (s.is_read) begin
									s.phase = PH_RESTART;
								end else begin
									s.shift_byte = s.held_data;
									s.phase = PH_WBIT;
								end
							end
							default: begin
								if (s.is_read) begin
									s.shift_byte = '0;
									s.phase = PH_RBIT;
								end else begin
									s.phase = PH_STOP;
								end
							end
						endcase
					end else begin
						s.ack_counter = s.ack_counter + 8'd1;
						if (s.ack_counter >= c.ack_wait_limit) begin
							// gave up waiting: abandon with a stop
							s.nack_seen = 1'b1;
							s.scl_drv = 1'b0;
							s.sda_drv = 1'b1;
							s.half_bit = 1'b0;
							s.phase = PH_STOP;
						end else begin
							s.scl_drv = 1'b1;
							s.sda_drv = 1'b1;
						end
					end
				end
				PH_RESTART: begin
					s.scl_drv = 1'b0;
					s.sda_drv = 1'b1;
					s.half_bit = 1'b0;
					s.phase = PH_START;
				end
				PH_RBIT: begin
					if (!s.half_bit) begin
						if (s.bit_count != 4'd0)
							s.shift_byte = {s.shift_byte[6:0], r.sda_in};
						s.scl_drv = 1'b0;
						s.sda_drv = 1'b1;
						if (s.bit_count >= 4'd8)
							s.phase = PH_MNACK;
						else
							s.half_bit = 1'b1;
					end else begin
						s.scl_drv = 1'b1;
						s.sda_drv = 1'b1;
						s.bit_count = s.bit_count + 4'd1;
						s.half_bit = 1'b0;
					end
				end
				PH_MNACK: begin
					s.scl_drv = 1'b1;
					s.sda_drv = 1'b1;
					s.half_bit = 1'b0;
					s.phase = PH_STOP;
				end
				PH_STOP: begin
					s.sda_drv = 1'b0;
					if (!s.half_bit) begin
						s.scl_drv = 1'b0;
						s.half_bit = 1'b1;
					end else begin
						s.scl_drv = 1'b1;
						s.half_bit = 1'b0;
						s.phase = PH_STOPEND;
					end
				end
				PH_STOPEND: begin
					s.scl_drv = 1'b1;
					s.sda_drv = 1'b1;
					done = 1'b1;
					if (s.is_read && !s.nack_seen)
						rdata = s.shift_byte;
					s.phase = PH_IDLE;
				end
				default: begin
					s.scl_drv = 1'b1;
					s.sda_drv = 1'b1;
					s.phase = PH_IDLE;
				end
			endcase
		end
		res.scl_level = s.scl_drv;
		res.sda_level = s.sda_drv;
		res.busy_res = (s.phase != PH_IDLE);
		res.done_res = done;
		res.read_data = rdata;
		res.ack_missing = s.nack_seen;
		res.rejected = rej;
		return res;
	endfunction

	function automatic bit field_bad(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Input driver: offers queued requests, with random gaps
	int unsigned gap_left = 0;
	result_t     predicted;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				predicted = i2c_bus_step(line_model, cfg_now, on_wire);
				expected_bus_results.push_back(predicted);
			end
			if (in_valid && !in_ready) begin
				// hold the payload until taken
			end else if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (!steady_tail && $urandom_range(0, 3) == 0) begin
				gap_left = $urandom_range(0, 6);
				in_valid <= 1'b0;
			end else if (tx_pending.size() > 0) begin
				on_wire = tx_pending.pop_front();
				req_type <= on_wire.req_type;
				word_address <= on_wire.word_address;
				write_data <= on_wire.write_data;
				sda_in <= on_wire.sda_in;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result monitor: compares each transaction against the oldest prediction
	int unsigned stall_left = 0;
	int unsigned hold_left = 0;
	bit          long_hold_done = 1'b0;
	bit          next_ready;
	result_t     want;
	bit          bad;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b1;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_bus_results.size() == 0) begin
					$display("%0t: unexpected result, expected none actual scl=%0b sda=%0b",
						$time, scl_level, sda_level);
					mismatches++;
				end else begin
					want = expected_bus_results.pop_front();
					bad = 1'b0;
					bad |= field_bad("scl_level", 8'(want.scl_level), 8'(scl_level));
					bad |= field_bad("sda_level", 8'(want.sda_level), 8'(sda_level));
					bad |= field_bad("busy_res", 8'(want.busy_res), 8'(busy_res));
					bad |= field_bad("done_res", 8'(want.done_res), 8'(done_res));
					bad |= field_bad("read_data", want.read_data, read_data);
					bad |= field_bad("ack_missing", 8'(want.ack_missing), 8'(ack_missing));
					bad |= field_bad("rejected", 8'(want.rejected), 8'(rejected));
					if (bad)
						mismatches++;
				end
			end
			// one long back-pressure stretch to fill the block
			if (results_seen >= LONG_HOLD_AT && !long_hold_done) begin
				hold_left = LONG_HOLD_CYCLES;
				long_hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				next_ready = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				next_ready = 1'b0;
			end else if (!steady_tail && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 6);
				next_ready = 1'b0;
			end else begin
				next_ready = 1'b1;
			end
			out_ready <= next_ready;
		end
	end

	// Watchdog on handshake activity
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: timeout", $time);
				$display("i2c_eeprom_byte_access_master verification failed");
				$finish;
			end
		end
	end

	// Queue a request and keep the planning copy of the sequencer in step
	task automatic queue_req(input logic [1:0] req, input logic [7:0] waddr,
			input logic [7:0] wdata, input logic sda);
		bus_req_t r;
		result_t  unused;
		r.req_type = req;
		r.word_address = waddr;
		r.write_data = wdata;
		r.sda_in = sda;
		tx_pending.push_back(r);
		unused = i2c_bus_step(plan_model, plan_cfg, r);
		items_planned++;
	endtask

	// Clock ticks until the bus is idle again, acting as the slave
	task automatic ticks_to_idle(input bit allow_nack);
		int unsigned guard;
		int unsigned ack_delay;
		bit          withhold;
		logic [1:0]  nack_byte;
		logic        sda;
		guard = 0;
		ack_delay = $urandom_range(0, 2);
		withhold = allow_nack && ($urandom_range(0, 2) == 0);
		nack_byte = 2'($urandom_range(0, 2));
		while (plan_model.phase != PH_IDLE && guard < 600) begin
			guard++;
			// occasional noise: commands while busy, ignored request type
			if ($urandom_range(0, 24) == 0)
				queue_req(2'($urandom_range(1, 3)), 8'($urandom), 8'($urandom),
					1'($urandom));
			if (plan_model.phase == PH_ACKWAIT && plan_model.half_bit) begin
				if (withhold && plan_model.byte_index == nack_byte) begin
					sda = 1'b1;
				end else if (ack_delay > 0) begin
					sda = 1'b1;
					ack_delay--;
				end else begin
					sda = 1'b0;
					ack_delay = $urandom_range(0, 2);
				end
			end else begin
				sda = 1'($urandom);
			end
			queue_req(REQ_TICK, 8'($urandom), 8'($urandom), sda);
		end
	endtask

	task automatic run_transfers(input int unsigned budget, input bit allow_nack);
		int unsigned start_count;
		int unsigned n;
		start_count = items_planned;
		while (items_planned - start_count < budget) begin
			// some idle traffic between transfers
			if ($urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 3);
				repeat (n)
					queue_req($urandom_range(0, 1) ? REQ_TICK : REQ_IGNORED,
						8'($urandom), 8'($urandom), 1'($urandom));
			end
			queue_req($urandom_range(0, 1) ? REQ_READ : REQ_WRITE,
				8'($urandom), 8'($urandom), 1'($urandom));
			ticks_to_idle(allow_nack);
		end
	endtask

	task automatic wait_drained();
		while (tx_pending.size() != 0 || expected_bus_results.size() != 0 || in_valid)
			@(posedge clk);
	endtask

	task automatic set_register(input logic idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_DEVICE_ADDRESS)
			cfg_now.device_address = value[6:0];
		else
			cfg_now.ack_wait_limit = value[7:0];
		plan_cfg = cfg_now;
	endtask

	task automatic next_setting(input logic [6:0] dev, input logic [7:0] limit);
		wait_drained();
		repeat (4) @(posedge clk);
		set_register(REG_DEVICE_ADDRESS, {25'd0, dev});
		set_register(REG_ACK_WAIT_LIMIT, {24'd0, limit});
	endtask

	initial begin
		line_model = released_bus();
		plan_model = released_bus();
		cfg_now.device_address = DEVICE_ADDRESS_RST;
		cfg_now.ack_wait_limit = ACK_WAIT_LIMIT_RST;
		plan_cfg = cfg_now;

		// directed: idle ticks, ignored type, commands while busy
		queue_req(REQ_TICK, 8'h00, 8'h00, 1'b0);
		queue_req(REQ_TICK, 8'hFF, 8'hFF, 1'b1);
		queue_req(REQ_IGNORED, 8'hFF, 8'hFF, 1'b1);
		queue_req(REQ_IGNORED, 8'h00, 8'h00, 1'b0);
		queue_req(REQ_WRITE, 8'hFF, 8'h00, 1'b0);
		queue_req(REQ_READ, 8'h00, 8'hFF, 1'b1);
		queue_req(REQ_WRITE, 8'hA5, 8'h5A, 1'b0);
		queue_req(REQ_IGNORED, 8'h3C, 8'hC3, 1'b1);
		for (int i = 0; i < 12; i++)
			queue_req(REQ_TICK, 8'h00, 8'hFF, i[0]);
		ticks_to_idle(1'b0);
		queue_req(REQ_READ, 8'hFF, 8'hFF, 1'b1);
		ticks_to_idle(1'b0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		run_transfers(40, 1'b0);
		next_setting(7'd0, 8'd255);
		run_transfers(30, 1'b0);
		next_setting(7'd127, 8'd1);
		run_transfers(30, 1'b1);
		next_setting(7'h2A, 8'd0);
		run_transfers(30, 1'b1);
		next_setting(7'h55, 8'd4);
		steady_tail = 1'b1;
		run_transfers(40, 1'b1);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_bus_results.size() == 0) begin
			$display("i2c_eeprom_byte_access_master verification clean");
		end else begin
			$display("i2c_eeprom_byte_access_master verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
